>>> sv/char_lcd_write_sequencer_core_macros.svh
// Assertion macros shared by the sequencer modules.
`ifndef CHAR_LCD_WRITE_SEQUENCER_CORE_MACROS_SVH
`define CHAR_LCD_WRITE_SEQUENCER_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define LCDWS_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCDWS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lcdws_pkg.sv
// Shared types, codes and constants of the character LCD write sequencer.
`default_nettype none
package lcdws_pkg;

   localparam int DEF_LINE_WIDTH = 16;
   localparam int DEF_TIMER_BITS = 16;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] MAX_SHIFTS = 7'd127;

   // LCD controller command bytes
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0D;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_HOME         = 8'h02;
   localparam logic [7:0] CMD_CURSOR_RIGHT = 8'h14;

   localparam logic [2:0] INIT_STEPS      = 3'd5;
   localparam logic [2:0] INIT_LAST_STEP  = 3'd4;
   localparam logic [2:0] INIT_CMD_WRITES = 3'd3;

   localparam logic [7:0] INIT_BYTES [5] = '{
      CMD_FUNCTION_SET, CMD_ENTRY_MODE, CMD_DISPLAY_ON, CMD_CLEAR, CMD_HOME
   };

   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_INIT  = 3'd1,
      OP_CHAR  = 3'd2,
      OP_RAW   = 3'd3,
      OP_CLEAR = 3'd4,
      OP_HOME  = 3'd5,
      OP_POS   = 3'd6
   } op_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PULSE      = 3'd0,
      CSR_SHORT_WAIT = 3'd1,
      CSR_CMD_WAIT   = 3'd2,
      CSR_CHAR_WAIT  = 3'd3,
      CSR_CLEAR_WAIT = 3'd4,
      CSR_POWER_WAIT = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_POWER = 4'b0010,
      PH_PULSE = 4'b0100,
      PH_WAIT  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [7:0]  pulse_ticks;
      logic [9:0]  short_wait_ticks;
      logic [9:0]  cmd_wait_ticks;
      logic [9:0]  char_wait_ticks;
      logic [15:0] clear_wait_ticks;
      logic [15:0] power_wait_ticks;
   } cfg_type;

   typedef struct packed {
      logic       is_request;
      op_type     op;
      logic [7:0] byte_value;
      logic [6:0] shifts;
   } item_type;

   typedef struct packed {
      logic       ok;
      logic       select;
      logic [7:0] data;
   } write_type;

   // Bus write for a given operation and sequence step.
   function automatic write_type write_for(input op_type op, input logic [2:0] step,
                                           input logic [7:0] raw);
      write_type w;
      w.ok     = 1'b1;
      w.select = 1'b0;
      w.data   = 8'h00;
      unique case (op)
         OP_INIT:  w.data = INIT_BYTES[(step < INIT_STEPS) ? step : INIT_LAST_STEP];
         OP_CHAR:  begin
            w.data   = raw;
            w.select = 1'b1;
         end
         OP_RAW:   w.data = raw;
         OP_CLEAR: w.data = CMD_CLEAR;
         OP_HOME:  w.data = CMD_HOME;
         OP_POS:   w.data = (step == 3'd0) ? CMD_HOME : CMD_CURSOR_RIGHT;
         default:  w.ok = 1'b0;
      endcase
      return w;
   endfunction

   // Enable-low time that follows a write.
   function automatic logic [15:0] wait_for(input op_type op, input logic [2:0] step,
                                            input cfg_type cfg);
      logic [15:0] t;
      unique case (op)
         OP_INIT: t = (step < INIT_CMD_WRITES) ? {6'd0, cfg.cmd_wait_ticks}
                                               : cfg.clear_wait_ticks;
         OP_CHAR: t = {6'd0, cfg.char_wait_ticks};
         OP_RAW:  t = {6'd0, cfg.short_wait_ticks};
         OP_POS:  t = (step == 3'd0) ? cfg.clear_wait_ticks : {6'd0, cfg.cmd_wait_ticks};
         default: t = cfg.clear_wait_ticks;
      endcase
      return t;
   endfunction

endpackage
`default_nettype wire

>>> sv/lcdws_front.sv
// Front end: takes request words and classifies them for the queue.
`default_nettype none
module lcdws_front #(
   parameter int LINE_WIDTH = lcdws_pkg::DEF_LINE_WIDTH
) (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_cmd,
   input  wire logic [7:0]         req_byte_value,
   input  wire logic               req_row,
   input  wire logic [5:0]         req_col,
   input  wire logic               push_ready,
   output logic                    push_valid,
   output lcdws_pkg::item_type     push_item
);

   logic [7:0] shift_sum;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   // cursor target = row * width + col, saturated to the 7-bit shift counter
   assign shift_sum = (req_row ? 8'(LINE_WIDTH) : 8'd0) + {2'b00, req_col};

   always_comb begin
      push_item.is_request = 1'b0;
      push_item.op         = lcdws_pkg::OP_NONE;
      push_item.byte_value = req_byte_value;
      push_item.shifts     = 7'd0;
      unique case (req_cmd) inside
         lcdws_pkg::OP_INIT, lcdws_pkg::OP_CHAR, lcdws_pkg::OP_RAW,
         lcdws_pkg::OP_CLEAR, lcdws_pkg::OP_HOME, lcdws_pkg::OP_POS: begin
            push_item.is_request = 1'b1;
            push_item.op         = lcdws_pkg::op_type'(req_cmd);
         end
         default: push_item.op = lcdws_pkg::OP_NONE;
      endcase
      if (push_item.op == lcdws_pkg::OP_POS) begin
         push_item.shifts = (shift_sum > {1'b0, lcdws_pkg::MAX_SHIFTS}) ?
                            lcdws_pkg::MAX_SHIFTS : shift_sum[6:0];
      end
   end

endmodule
`default_nettype wire

>>> sv/lcdws_queue.sv
// Short FIFO of classified words between the front end and the engine.
`default_nettype none
module lcdws_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire lcdws_pkg::item_type push_item,
   output logic                     push_ready,
   output logic                     pop_valid,
   output lcdws_pkg::item_type      pop_item,
   input  wire logic                pop_en
);
`include "char_lcd_write_sequencer_core_macros.svh"

   localparam logic [lcdws_pkg::QCNT_BITS-1:0] DEPTH_CNT =
      lcdws_pkg::QCNT_BITS'(lcdws_pkg::QUEUE_DEPTH);
   localparam logic [lcdws_pkg::QPTR_BITS-1:0] LAST_PTR =
      lcdws_pkg::QPTR_BITS'(lcdws_pkg::QUEUE_DEPTH - 1);

   lcdws_pkg::item_type                 entry_ff [lcdws_pkg::QUEUE_DEPTH];
   logic [lcdws_pkg::QPTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [lcdws_pkg::QPTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [lcdws_pkg::QCNT_BITS-1:0]     count_ff, count_in;
   logic                                push_en;

   assign push_ready = (count_ff != DEPTH_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push_en    = push_valid && push_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop_en)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push_en && !pop_en)      count_in = count_ff + 1'b1;
      else if (pop_en && !push_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) entry_ff[wr_ptr_ff] <= push_item;
   end

   `LCDWS_ASSERT(a_queue_count_range, count_ff <= DEPTH_CNT, "queue count over depth")
   `LCDWS_ASSERT(a_queue_no_underflow, !pop_en || (count_ff != '0), "pop from empty queue")
   `LCDWS_ASSERT_NEXT(a_queue_push_nonempty, push_en, count_ff != '0, "push lost")

endmodule
`default_nettype wire

>>> sv/lcdws_engine.sv
// Back end: bus write sequencer state machine and registered result stage.
`default_nettype none
module lcdws_engine #(
   parameter int TIMER_BITS = lcdws_pkg::DEF_TIMER_BITS
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lcdws_pkg::cfg_type  cfg,
   input  wire logic                q_valid,
   input  wire lcdws_pkg::item_type q_item,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_reg_select,
   output logic                     rsp_read_write,
   output logic                     rsp_enable,
   output logic [7:0]               rsp_bus_byte,
   output logic                     rsp_busy_res,
   output logic                     rsp_rejected
);
`include "char_lcd_write_sequencer_core_macros.svh"

   localparam logic [24:0] TIMER_MAX = 25'((1 << TIMER_BITS) - 1);

   // loaded duration: zero reads as one unless allowed, saturates to timer range
   function automatic logic [TIMER_BITS-1:0] load_time(input logic [15:0] v,
                                                       input logic allow_zero);
      logic [24:0] ext;
      ext = {9'd0, v};
      if (!allow_zero && (v == 16'd0)) ext = 25'd1;
      if (ext > TIMER_MAX) ext = TIMER_MAX;
      return ext[TIMER_BITS-1:0];
   endfunction

   lcdws_pkg::phase_type    phase_ff, phase_in, ph_a;
   logic [TIMER_BITS-1:0]   timer_ff, timer_in, tmr_a, tmr_dec;
   logic [2:0]              step_ff, step_in, step_a, step_nx;
   lcdws_pkg::op_type       op_ff, op_in, op_a;
   logic [6:0]              shifts_ff, shifts_in, sh_a, sh_nx;
   logic [7:0]              raw_ff, raw_in, raw_a;
   logic [7:0]              hbyte_ff, hbyte_in, hb_a;
   logic                    hsel_ff, hsel_in, hs_a;
   logic                    rej;
   lcdws_pkg::write_type    wr_a, wr_b;

   logic       rsp_valid_ff;
   logic       rsp_select_ff, rsp_enable_ff, rsp_busy_ff, rsp_rejected_ff;
   logic [7:0] rsp_byte_ff;

   assign q_pop = q_valid && (!rsp_valid_ff || rsp_ready);

   // request side of the tick
   always_comb begin
      ph_a  = phase_ff;
      tmr_a = timer_ff;
      step_a = step_ff;
      op_a  = op_ff;
      raw_a = raw_ff;
      sh_a  = shifts_ff;
      hb_a  = hbyte_ff;
      hs_a  = hsel_ff;
      rej   = 1'b0;
      wr_a  = lcdws_pkg::write_for(q_item.op, 3'd0, q_item.byte_value);
      if (q_item.is_request && (phase_ff != lcdws_pkg::PH_IDLE)) begin
         rej = 1'b1;
      end else if (q_item.is_request) begin
         op_a   = q_item.op;
         step_a = 3'd0;
         raw_a  = q_item.byte_value;
         sh_a   = q_item.shifts;
         if ((q_item.op == lcdws_pkg::OP_INIT) && (cfg.power_wait_ticks != 16'd0)) begin
            ph_a  = lcdws_pkg::PH_POWER;
            tmr_a = load_time(cfg.power_wait_ticks, 1'b1);
         end else if (wr_a.ok) begin
            hb_a  = wr_a.data;
            hs_a  = wr_a.select;
            ph_a  = lcdws_pkg::PH_PULSE;
            tmr_a = load_time({8'd0, cfg.pulse_ticks}, 1'b0);
         end else begin
            ph_a = lcdws_pkg::PH_IDLE;
         end
      end
   end

   // timer side of the tick
   always_comb begin
      tmr_dec = (tmr_a != '0) ? tmr_a - 1'b1 : '0;
      step_nx = step_a;
      sh_nx   = sh_a;
      if (op_a == lcdws_pkg::OP_INIT) begin
         step_nx = step_a + 3'd1;
      end else if (op_a == lcdws_pkg::OP_POS) begin
         if (step_a == 3'd0)        step_nx = 3'd1;
         else if (sh_a != 7'd0)     sh_nx   = sh_a - 7'd1;
      end
      wr_b = lcdws_pkg::write_for(op_a, (ph_a == lcdws_pkg::PH_WAIT) ? step_nx : step_a,
                                  raw_a);

      phase_in  = ph_a;
      timer_in  = tmr_a;
      step_in   = step_a;
      op_in     = op_a;
      raw_in    = raw_a;
      shifts_in = sh_a;
      hbyte_in  = hb_a;
      hsel_in   = hs_a;
      if (ph_a != lcdws_pkg::PH_IDLE) begin
         timer_in = tmr_dec;
         if (tmr_dec == '0) begin
            unique case (ph_a)
               lcdws_pkg::PH_POWER: begin
                  if (wr_b.ok) begin
                     hbyte_in = wr_b.data;
                     hsel_in  = wr_b.select;
                     phase_in = lcdws_pkg::PH_PULSE;
                     timer_in = load_time({8'd0, cfg.pulse_ticks}, 1'b0);
                  end else begin
                     phase_in = lcdws_pkg::PH_IDLE;
                  end
               end
               lcdws_pkg::PH_PULSE: begin
                  phase_in = lcdws_pkg::PH_WAIT;
                  timer_in = load_time(lcdws_pkg::wait_for(op_a, step_a, cfg), 1'b0);
               end
               lcdws_pkg::PH_WAIT: begin
                  phase_in = lcdws_pkg::PH_IDLE;
                  if (op_a == lcdws_pkg::OP_INIT || op_a == lcdws_pkg::OP_POS) begin
                     step_in   = step_nx;
                     shifts_in = sh_nx;
                  end
                  if (((op_a == lcdws_pkg::OP_INIT) && (step_nx < lcdws_pkg::INIT_STEPS)) ||
                      ((op_a == lcdws_pkg::OP_POS) && (sh_nx != 7'd0))) begin
                     hbyte_in = wr_b.data;
                     hsel_in  = wr_b.select;
                     phase_in = lcdws_pkg::PH_PULSE;
                     timer_in = load_time({8'd0, cfg.pulse_ticks}, 1'b0);
                  end
               end
               default: phase_in = ph_a;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lcdws_pkg::PH_IDLE;
         timer_ff  <= '0;
         step_ff   <= 3'd0;
         op_ff     <= lcdws_pkg::OP_NONE;
         shifts_ff <= 7'd0;
         raw_ff    <= 8'd0;
         hbyte_ff  <= 8'd0;
         hsel_ff   <= 1'b0;
      end else if (q_pop) begin
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
         step_ff   <= step_in;
         op_ff     <= op_in;
         shifts_ff <= shifts_in;
         raw_ff    <= raw_in;
         hbyte_ff  <= hbyte_in;
         hsel_ff   <= hsel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (q_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_select_ff   <= hs_a;
         rsp_byte_ff     <= hb_a;
         rsp_enable_ff   <= (ph_a == lcdws_pkg::PH_PULSE);
         rsp_busy_ff     <= (ph_a != lcdws_pkg::PH_IDLE);
         rsp_rejected_ff <= rej;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_select_ff;
   assign rsp_read_write = 1'b0;
   assign rsp_enable     = rsp_enable_ff;
   assign rsp_bus_byte   = rsp_byte_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_rejected   = rsp_rejected_ff;

   `LCDWS_ASSERT(a_eng_enable_busy, !(rsp_valid_ff && rsp_enable_ff) || rsp_busy_ff, "enable while not busy")
   `LCDWS_ASSERT(a_eng_reject_busy, !(rsp_valid_ff && rsp_rejected_ff) || rsp_busy_ff, "reject while idle")
   `LCDWS_ASSERT(a_eng_shifts_pos, (shifts_ff == 7'd0) || (op_ff == lcdws_pkg::OP_POS), "shifts outside position")

endmodule
`default_nettype wire

>>> sv/char_lcd_write_sequencer_core.sv
// Top level of the character LCD write sequencer: config registers and datapath.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   req      | req_valid/ready, cmd, byte_value, row, col | in, one word per 1 us tick
//   rsp      | rsp_valid/ready, pin levels, busy, rejected | out, one word per tick
//   csr      | csr_write_en, csr_index, csr_wdata       | in, write only, no wait
//
// Each request word yields exactly one response word, in order.
// Throughput: one word per clock unless rsp stalls; a word reaches rsp_valid
// through the queue and the output register. The engine state machine updates
// once per word, so the per-tick sequencer step sets the clock period (one timer
// decrement plus write selection). A two-word queue decouples the front end from
// the engine; rsp stalls back up through the queue to req_ready. Reset is synchronous.
`default_nettype none
module char_lcd_write_sequencer_core #(
   parameter int LINE_WIDTH = lcdws_pkg::DEF_LINE_WIDTH,
   parameter int TIMER_BITS = lcdws_pkg::DEF_TIMER_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_cmd,
   input  wire logic [7:0]                          req_byte_value,
   input  wire logic                                req_row,
   input  wire logic [5:0]                          req_col,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_reg_select,
   output logic                                     rsp_read_write,
   output logic                                     rsp_enable,
   output logic [7:0]                               rsp_bus_byte,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_rejected,
   input  wire logic                                csr_write_en,
   input  wire logic [lcdws_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [lcdws_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // config registers, reset to the LCD's datasheet-ish defaults
   lcdws_pkg::cfg_type  cfg_ff, cfg_in;

   // front -> queue
   logic                push_valid, push_ready;
   lcdws_pkg::item_type push_item;

   // queue -> engine
   logic                q_valid, q_pop;
   lcdws_pkg::item_type q_item;

   // Register writes are masked to each register's width; unknown index is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            lcdws_pkg::CSR_PULSE:      cfg_in.pulse_ticks      = csr_wdata[7:0];
            lcdws_pkg::CSR_SHORT_WAIT: cfg_in.short_wait_ticks = csr_wdata[9:0];
            lcdws_pkg::CSR_CMD_WAIT:   cfg_in.cmd_wait_ticks   = csr_wdata[9:0];
            lcdws_pkg::CSR_CHAR_WAIT:  cfg_in.char_wait_ticks  = csr_wdata[9:0];
            lcdws_pkg::CSR_CLEAR_WAIT: cfg_in.clear_wait_ticks = csr_wdata;
            lcdws_pkg::CSR_POWER_WAIT: cfg_in.power_wait_ticks = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks      <= 8'd1;
         cfg_ff.short_wait_ticks <= 10'd1;
         cfg_ff.cmd_wait_ticks   <= 10'd38;
         cfg_ff.char_wait_ticks  <= 10'd75;
         cfg_ff.clear_wait_ticks <= 16'd15201;
         cfg_ff.power_wait_ticks <= 16'd5000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode the request and compute the cursor shift count
   lcdws_front #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_col        (req_col),
      .push_ready     (push_ready),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   lcdws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_en     (q_pop)
   );

   // one sequencer step per word, result held in the output register
   lcdws_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_reg_select (rsp_reg_select),
      .rsp_read_write (rsp_read_write),
      .rsp_enable     (rsp_enable),
      .rsp_bus_byte   (rsp_bus_byte),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_rejected   (rsp_rejected)
   );

endmodule
`default_nettype wire
